### rtl/core/sue_pkg.sv
// Package for the string literal unescaper: word types, character codes, decode helpers.
`default_nettype none

package sue_pkg;

   // Character codes used by the escape decoder
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_7      = 8'h37;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;
   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_V   = 8'h76;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_X   = 8'h78;

   // Control codes produced by the named escapes
   localparam logic [7:0] CODE_BS = 8'h08;
   localparam logic [7:0] CODE_HT = 8'h09;
   localparam logic [7:0] CODE_LF = 8'h0A;
   localparam logic [7:0] CODE_VT = 8'h0B;
   localparam logic [7:0] CODE_FF = 8'h0C;
   localparam logic [7:0] CODE_CR = 8'h0D;

   // Escape decoder mode
   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_ESCAPE = 4'b0010,
      MODE_OCTAL  = 4'b0100,
      MODE_HEX    = 4'b1000
   } mode_type;

   // Input word
   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       warn_bad_escape;
      logic       warn_no_hex_digit;
      logic       err_dangling_escape;
   } rsp_word_type;

   // Up to two results from one input word, first goes out first
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_pair_type;

   // Hex digit decode: bit 4 is valid, bits 3:0 the nibble
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         res = {1'b1, 4'(c - CHAR_0)};
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         res = {1'b1, 4'(c - CHAR_LC_A + 8'd10)};
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         res = {1'b1, 4'(c - CHAR_UC_A + 8'd10)};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sue_stream_if.sv
// Valid/ready stream channel carrying one payload word.
`default_nettype none

interface sue_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/sue_decode.sv
// Escape decoder: mode state and the per-word decode into up to two results.
`default_nettype none

module sue_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire sue_pkg::req_word_type in_word,
   output sue_pkg::rsp_pair_type      pair
);

   sue_pkg::mode_type mode_ff, mode_in;
   logic [8:0]        value_ff, value_in;
   logic [1:0]        oct_cnt_ff, oct_cnt_in;
   logic              hex_seen_ff, hex_seen_in;

   logic [7:0]            c;
   logic                  last;
   logic                  is_oct;
   logic [4:0]            hex;
   logic                  plain_emit;
   sue_pkg::rsp_word_type plain_word;
   sue_pkg::mode_type     plain_mode;
   sue_pkg::rsp_word_type esc_word;
   logic [8:0]            oct_value;
   logic [1:0]            oct_cnt_next;
   logic [7:0]            hex_value;

   assign c      = in_word.char_byte;
   assign last   = in_word.is_last;
   assign is_oct = (c inside {[sue_pkg::CHAR_0 : sue_pkg::CHAR_7]});
   assign hex    = sue_pkg::hex_digit(c);

   // Normal-mode handling, also used for the byte that ends a numeric escape
   always_comb begin
      plain_word = '0;
      plain_emit = 1'b1;
      plain_mode = sue_pkg::MODE_NORMAL;
      if (c == sue_pkg::CHAR_BSLASH && !last) begin
         plain_emit = 1'b0;
         plain_mode = sue_pkg::MODE_ESCAPE;
      end else if (c == sue_pkg::CHAR_BSLASH) begin
         plain_word.out_byte            = sue_pkg::CHAR_BSLASH;
         plain_word.out_last            = 1'b1;
         plain_word.err_dangling_escape = 1'b1;
      end else begin
         plain_word.out_byte = c;
         plain_word.out_last = last;
      end
   end

   // Single-character escapes after a backslash
   always_comb begin
      esc_word          = '0;
      esc_word.out_last = last;
      case (c)
         sue_pkg::CHAR_QUOTE:  esc_word.out_byte = c;
         sue_pkg::CHAR_BSLASH: esc_word.out_byte = c;
         sue_pkg::CHAR_LC_B:   esc_word.out_byte = sue_pkg::CODE_BS;
         sue_pkg::CHAR_LC_T:   esc_word.out_byte = sue_pkg::CODE_HT;
         sue_pkg::CHAR_LC_N:   esc_word.out_byte = sue_pkg::CODE_LF;
         sue_pkg::CHAR_LC_V:   esc_word.out_byte = sue_pkg::CODE_VT;
         sue_pkg::CHAR_LC_F:   esc_word.out_byte = sue_pkg::CODE_FF;
         sue_pkg::CHAR_LC_R:   esc_word.out_byte = sue_pkg::CODE_CR;
         default: begin
            esc_word.out_byte        = c;
            esc_word.warn_bad_escape = 1'b1;
         end
      endcase
   end

   assign oct_value    = {value_ff[5:0], c[2:0]};
   assign oct_cnt_next = 2'(oct_cnt_ff + 2'd1);
   assign hex_value    = {value_ff[3:0], hex[3:0]};

   // Mode transitions and result selection
   always_comb begin
      mode_in     = mode_ff;
      value_in    = value_ff;
      oct_cnt_in  = oct_cnt_ff;
      hex_seen_in = hex_seen_ff;
      pair        = '0;
      case (mode_ff)
         sue_pkg::MODE_NORMAL: begin
            pair.count = {1'b0, plain_emit};
            pair.first = plain_word;
            mode_in    = plain_mode;
         end
         sue_pkg::MODE_ESCAPE: begin
            mode_in = sue_pkg::MODE_NORMAL;
            if (is_oct) begin
               value_in   = {6'd0, c[2:0]};
               oct_cnt_in = 2'd1;
               if (last) begin
                  pair.count          = 2'd1;
                  pair.first.out_byte = {5'd0, c[2:0]};
                  pair.first.out_last = 1'b1;
               end else begin
                  mode_in = sue_pkg::MODE_OCTAL;
               end
            end else if (c == sue_pkg::CHAR_LC_X) begin
               value_in    = 9'd0;
               hex_seen_in = 1'b0;
               if (last) begin
                  pair.count                   = 2'd1;
                  pair.first.out_last          = 1'b1;
                  pair.first.warn_no_hex_digit = 1'b1;
               end else begin
                  mode_in = sue_pkg::MODE_HEX;
               end
            end else begin
               pair.count = 2'd1;
               pair.first = esc_word;
            end
         end
         sue_pkg::MODE_OCTAL: begin
            if (is_oct && oct_cnt_ff != 2'd3) begin
               value_in   = oct_value;
               oct_cnt_in = oct_cnt_next;
               if (oct_cnt_next == 2'd3 || last) begin
                  mode_in             = sue_pkg::MODE_NORMAL;
                  pair.count          = 2'd1;
                  pair.first.out_byte = oct_value[7:0];
                  pair.first.out_last = last;
               end
            end else begin
               // flush pending value, then the ending byte as normal
               pair.first.out_byte = value_ff[7:0];
               pair.second         = plain_word;
               pair.count          = plain_emit ? 2'd2 : 2'd1;
               mode_in             = plain_mode;
            end
         end
         sue_pkg::MODE_HEX: begin
            if (hex[4]) begin
               value_in    = {1'b0, hex_value};
               hex_seen_in = 1'b1;
               if (last) begin
                  mode_in             = sue_pkg::MODE_NORMAL;
                  pair.count          = 2'd1;
                  pair.first.out_byte = hex_value;
                  pair.first.out_last = 1'b1;
               end
            end else begin
               pair.first.out_byte          = value_ff[7:0];
               pair.first.warn_no_hex_digit = !hex_seen_ff;
               pair.second                  = plain_word;
               pair.count                   = plain_emit ? 2'd2 : 2'd1;
               mode_in                      = plain_mode;
            end
         end
         default: begin
            mode_in = sue_pkg::MODE_NORMAL;
         end
      endcase
   end

   // State registers, updated when a word is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sue_pkg::MODE_NORMAL;
         value_ff    <= 9'd0;
         oct_cnt_ff  <= 2'd0;
         hex_seen_ff <= 1'b0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         value_ff    <= value_in;
         oct_cnt_ff  <= oct_cnt_in;
         hex_seen_ff <= hex_seen_in;
      end
   end

`ifndef SYNTHESIS
   // the literal always closes back in normal mode
   a_last_to_normal: assert property (@(posedge clock) disable iff (reset)
      advance && in_word.is_last |=> mode_ff == sue_pkg::MODE_NORMAL)
      else $error("mode not normal after last word");
`endif

endmodule

`default_nettype wire

### rtl/core/sue_rsp_buf.sv
// Two-slot result buffer that drives the result channel.
`default_nettype none

module sue_rsp_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   input  wire sue_pkg::rsp_pair_type pair,
   output logic                       load_ready,
   sue_stream_if.source               rsp_chan
);

   logic [1:0]            cnt_ff, cnt_in;
   sue_pkg::rsp_word_type slot0_ff, slot0_in;
   sue_pkg::rsp_word_type slot1_ff, slot1_in;
   logic                  pop;
   logic                  load;

   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_chan.data  = slot0_ff;

   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign load_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign load       = load_valid && load_ready;

   // Load a new pair or shift the second slot forward
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = pair.count;
         slot0_in = pair.first;
         slot1_in = pair.second;
      end else if (pop) begin
         cnt_in   = 2'(cnt_ff - 2'd1);
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result count out of range");

   a_pair_load: assert property (@(posedge clock) disable iff (reset)
      load && pair.count == 2'd2 |=> cnt_ff == 2'd2 && slot1_ff == $past(pair.second))
      else $error("pair not held after load");

   a_shift: assert property (@(posedge clock) disable iff (reset)
      pop && cnt_ff == 2'd2 |=> cnt_ff == 2'd1 && slot0_ff == $past(slot1_ff))
      else $error("second result not shifted forward");
`endif

endmodule

`default_nettype wire

### rtl/core/string_literal_unescaper_top.sv
// Top level of the string literal unescaper.
//
//   channel   | dir | word                                    | handshake
//   req_chan  | in  | char_byte, is_last                      | valid/ready
//   rsp_chan  | out | out_byte, out_last, warn/err flags      | valid/ready
//
// One input word per cycle while the result side takes each result and each
// word yields at most one result; a non-digit byte ending an octal or hex
// escape yields two (one if it opens an escape) and holds input until the
// second is taken. Words pass the input register, then the two-slot buffer.
// Reset is synchronous and returns the decoder to normal mode, buffers empty.
// A stalled result side stops input after the input register fills.
`default_nettype none

module string_literal_unescaper_top (
   input  wire logic  clock,
   input  wire logic  reset,
   sue_stream_if.sink   req_chan,
   sue_stream_if.source rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   sue_pkg::req_word_type in_word_ff;
   logic                  accept;
   logic                  advance;
   logic                  load_ready;
   sue_pkg::rsp_pair_type pair;

   assign advance        = in_valid_ff && load_ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_chan.data;
      end
   end

   sue_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_word (in_word_ff),
      .pair    (pair)
   );

   sue_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .pair       (pair),
      .load_ready (load_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### dv/string_literal_unescaper_top_tb.sv
// Testbench for the string literal unescaper: directed table, random literals, scoreboard.
`default_nettype none

module string_literal_unescaper_top_tb;
   import sue_pkg::*;

   // Directed stimulus row: typed marks a row whose single result is given inline
   typedef struct packed {
      logic [7:0]   ch;
      logic         last;
      logic         typed;
      rsp_word_type want;
   } dir_row_type;

   localparam rsp_word_type NO_WANT = '0;
   localparam int RAND_ITEMS_PER_PHASE = 430;
   localparam int LONG_HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES         = 20;

   localparam logic [7:0] NAMED_ESCAPES [8] = '{
      CHAR_QUOTE, CHAR_BSLASH, CHAR_LC_B, CHAR_LC_T,
      CHAR_LC_N, CHAR_LC_V, CHAR_LC_F, CHAR_LC_R
   };

   localparam dir_row_type DIRECTED_ROWS [25] = '{
      // extremes right after reset
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
      // escaped quote
      '{CHAR_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{CHAR_QUOTE,  1'b0, 1'b0, NO_WANT},
      // three octal digits, emitted on the third, high bit dropped
      '{CHAR_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{CHAR_7,      1'b0, 1'b0, NO_WANT},
      '{CHAR_7,      1'b0, 1'b0, NO_WANT},
      '{CHAR_7,      1'b0, 1'b0, NO_WANT},
      // octal ended by a plain byte: two results
      '{CHAR_BSLASH,       1'b0, 1'b0, NO_WANT},
      '{CHAR_0 + 8'd1,     1'b0, 1'b0, NO_WANT},
      '{8'h5A,             1'b0, 1'b0, NO_WANT},
      // hex closed by the final byte
      '{CHAR_BSLASH,   1'b0, 1'b0, NO_WANT},
      '{CHAR_LC_X,     1'b0, 1'b0, NO_WANT},
      '{CHAR_0 + 8'd1, 1'b0, 1'b0, NO_WANT},
      '{CHAR_UC_A + 8'd1, 1'b1, 1'b0, NO_WANT},
      // hex with no digits, ended by a plain byte
      '{CHAR_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{CHAR_LC_X,   1'b0, 1'b0, NO_WANT},
      '{8'h67,       1'b0, 1'b0, NO_WANT},
      // unknown escape on the final byte
      '{CHAR_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{8'h71,       1'b1, 1'b1, '{8'h71, 1'b1, 1'b1, 1'b0, 1'b0}},
      // lone backslash on the final byte
      '{CHAR_BSLASH, 1'b1, 1'b1, '{CHAR_BSLASH, 1'b1, 1'b0, 1'b0, 1'b1}},
      // hex escape opened on the final byte
      '{CHAR_BSLASH, 1'b0, 1'b0, NO_WANT},
      '{CHAR_LC_X,   1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
      // octal escape opened on the final byte
      '{CHAR_BSLASH,   1'b0, 1'b0, NO_WANT},
      '{CHAR_0 + 8'd5, 1'b1, 1'b1, '{8'h05, 1'b1, 1'b0, 1'b0, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset;

   sue_stream_if #(.payload_type(req_word_type)) req_if ();
   sue_stream_if #(.payload_type(rsp_word_type)) rsp_if ();

   string_literal_unescaper_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decoder state mirrored by the predictor
   mode_type   esc_mode;
   logic [8:0] esc_value;
   logic [1:0] oct_count;
   logic       hex_seen;

   rsp_word_type step_out [$];
   rsp_word_type due_words [$];

   int sender_idle_pct;
   int rcv_stall_pct;
   int hold_req_count;
   int error_count;
   int words_sent;
   int literals_sent;
   int results_checked;
   int unknown_seen;
   int nohex_seen;
   int dangle_seen;

   function automatic rsp_word_type mk_word(logic [7:0] b, logic last, logic unk,
                                            logic nohex, logic dangle);
      return '{b, last, unk, nohex, dangle};
   endfunction

   // Append one predicted result for the current byte
   task automatic put_out(input rsp_word_type w);
      step_out = {step_out, w};
   endtask

   // Byte handled as in normal mode
   task automatic plain_char(input logic [7:0] ch, input logic last);
      if (ch == CHAR_BSLASH) begin
         if (last) begin
            esc_mode = MODE_NORMAL;
            put_out(mk_word(CHAR_BSLASH, 1'b1, 1'b0, 1'b0, 1'b1));
         end else begin
            esc_mode = MODE_ESCAPE;
         end
      end else begin
         esc_mode = MODE_NORMAL;
         put_out(mk_word(ch, last, 1'b0, 1'b0, 1'b0));
      end
   endtask

   // One input byte through the decoder; results go to step_out
   task automatic unescape_byte(input logic [7:0] ch, input logic last);
      logic [4:0] nib;
      logic       is_oct;
      is_oct = (ch >= CHAR_0) && (ch <= CHAR_7);
      case (esc_mode)
         MODE_ESCAPE: begin
            esc_mode = MODE_NORMAL;
            if (is_oct) begin
               esc_value = 9'(ch - CHAR_0);
               oct_count = 2'd1;
               if (last) put_out(mk_word(esc_value[7:0], 1'b1, 1'b0, 1'b0, 1'b0));
               else esc_mode = MODE_OCTAL;
            end else if (ch == CHAR_QUOTE || ch == CHAR_BSLASH) begin
               put_out(mk_word(ch, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_B) begin
               put_out(mk_word(CODE_BS, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_T) begin
               put_out(mk_word(CODE_HT, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_N) begin
               put_out(mk_word(CODE_LF, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_V) begin
               put_out(mk_word(CODE_VT, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_F) begin
               put_out(mk_word(CODE_FF, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_R) begin
               put_out(mk_word(CODE_CR, last, 1'b0, 1'b0, 1'b0));
            end else if (ch == CHAR_LC_X) begin
               esc_value = '0;
               hex_seen  = 1'b0;
               if (last) put_out(mk_word(8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
               else esc_mode = MODE_HEX;
            end else begin
               put_out(mk_word(ch, last, 1'b1, 1'b0, 1'b0));
            end
         end
         MODE_OCTAL: begin
            if (is_oct && oct_count < 2'd3) begin
               esc_value = {esc_value[5:0], ch[2:0]};
               oct_count = oct_count + 2'd1;
               if (oct_count == 2'd3 || last) begin
                  esc_mode = MODE_NORMAL;
                  put_out(mk_word(esc_value[7:0], last, 1'b0, 1'b0, 1'b0));
               end
            end else begin
               put_out(mk_word(esc_value[7:0], 1'b0, 1'b0, 1'b0, 1'b0));
               plain_char(ch, last);
            end
         end
         MODE_HEX: begin
            nib = '0;
            if (ch >= CHAR_0 && ch <= CHAR_9)
               nib = {1'b1, 4'(ch - CHAR_0)};
            else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F)
               nib = {1'b1, 4'(ch - CHAR_LC_A + 8'd10)};
            else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F)
               nib = {1'b1, 4'(ch - CHAR_UC_A + 8'd10)};
            if (nib[4]) begin
               // only the last two digits survive
               esc_value = {1'b0, esc_value[3:0], nib[3:0]};
               hex_seen  = 1'b1;
               if (last) begin
                  esc_mode = MODE_NORMAL;
                  put_out(mk_word(esc_value[7:0], 1'b1, 1'b0, 1'b0, 1'b0));
               end
            end else begin
               put_out(mk_word(esc_value[7:0], 1'b0, 1'b0, !hex_seen, 1'b0));
               plain_char(ch, last);
            end
         end
         default: plain_char(ch, last);
      endcase
   endtask

   // Offer one word, wait for the handshake, then record what it should produce
   task automatic send_word(input logic [7:0] ch, input logic last, input logic typed,
                            input rsp_word_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= '{char_byte: ch, is_last: last};
      do @(posedge clock); while (!req_if.ready);
      step_out.delete();
      unescape_byte(ch, last);
      if (typed) due_words = {due_words, want};
      else foreach (step_out[i]) due_words = {due_words, step_out[i]};
      words_sent++;
   endtask

   // One random literal, mostly well-formed escapes with random content
   task automatic send_literal();
      logic [7:0] body [$];
      logic [7:0] hc;
      int         kind;
      if ($urandom_range(9) == 0) begin
         // noise: raw bytes, stray backslashes anywhere
         repeat ($urandom_range(1, 6)) body = {body, 8'($urandom_range(255))};
      end else begin
         repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               body = {body, 8'($urandom_range(255))};
            end else if (kind < 50) begin
               body = {body, CHAR_BSLASH};
               body = {body, NAMED_ESCAPES[$urandom_range(7)]};
            end else if (kind < 64) begin
               body = {body, CHAR_BSLASH};
               repeat ($urandom_range(1, 4)) body = {body, CHAR_0 + 8'($urandom_range(7))};
            end else if (kind < 80) begin
               body = {body, CHAR_BSLASH};
               body = {body, CHAR_LC_X};
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(2))
                     0:       hc = CHAR_0 + 8'($urandom_range(9));
                     1:       hc = CHAR_LC_A + 8'($urandom_range(5));
                     default: hc = CHAR_UC_A + 8'($urandom_range(5));
                  endcase
                  body = {body, hc};
               end
            end else if (kind < 92) begin
               body = {body, CHAR_BSLASH};
               body = {body, 8'($urandom_range(255))};
            end else begin
               body = {body, CHAR_BSLASH};
            end
         end
      end
      foreach (body[i]) send_word(body[i], i == body.size() - 1, 1'b0, NO_WANT);
      literals_sent++;
   endtask

   // Sender pause until every due word has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      int holds_done;
      hold_left     = 0;
      holds_done    = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (holds_done != hold_req_count) begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // Scoreboard: compare each result word against the oldest due word
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (due_words.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: unexpected result word byte=%02h last=%b flags=%b%b%b",
                        got.out_byte, got.out_last, got.warn_bad_escape,
                        got.warn_no_hex_digit, got.err_dangling_escape);
         end else begin
            want = due_words.pop_front();
            results_checked++;
            unknown_seen += got.warn_bad_escape;
            nohex_seen   += got.warn_no_hex_digit;
            dangle_seen  += got.err_dangling_escape;
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                got.warn_bad_escape !== want.warn_bad_escape ||
                got.warn_no_hex_digit !== want.warn_no_hex_digit ||
                got.err_dangling_escape !== want.err_dangling_escape) begin
               error_count++;
               if (error_count <= 10)
                  $display(
                     "ERROR: word %0d byte %02h/%02h last %b/%b flags %b%b%b/%b%b%b (exp/got)",
                     results_checked, want.out_byte, got.out_byte,
                     want.out_last, got.out_last,
                     want.warn_bad_escape, want.warn_no_hex_digit,
                     want.err_dangling_escape,
                     got.warn_bad_escape, got.warn_no_hex_digit,
                     got.err_dangling_escape);
            end
         end
      end
   end

   // Main sequence
   initial begin
      int phase_words;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.data     = '0;
      sender_idle_pct = 0;
      rcv_stall_pct   = 0;
      hold_req_count  = 0;
      error_count     = 0;
      words_sent      = 0;
      literals_sent   = 0;
      results_checked = 0;
      unknown_seen    = 0;
      nohex_seen      = 0;
      dangle_seen     = 0;
      esc_mode        = MODE_NORMAL;
      esc_value       = '0;
      oct_count       = '0;
      hex_seen        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
      wait_drained();

      // random literals: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1:       begin sender_idle_pct = 74; rcv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rcv_stall_pct = 74; end
            default: begin sender_idle_pct = 19; rcv_stall_pct = 19; end
         endcase
         phase_words = words_sent;
         while (words_sent - phase_words < RAND_ITEMS_PER_PHASE) begin
            // halfway through the busy phase, hold the result side off for a while
            if (phase == 0 && hold_req_count == 0 &&
                words_sent - phase_words >= RAND_ITEMS_PER_PHASE / 2)
               hold_req_count = 1;
            send_literal();
         end
         wait_drained();
      end

      // watch for stray results after the last due word
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d literals, %0d input words, %0d result words checked",
               literals_sent, words_sent, results_checked);
      $display("flags seen: %0d unknown escape, %0d empty hex, %0d dangling; %0d failures",
               unknown_seen, nohex_seen, dangle_seen, error_count);
      if (error_count == 0 && due_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("ERROR: timeout with %0d result words still due", due_words.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/core/sue_pkg.sv
rtl/core/sue_stream_if.sv
rtl/core/sue_decode.sv
rtl/core/sue_rsp_buf.sv
rtl/core/string_literal_unescaper_top.sv
dv/string_literal_unescaper_top_tb.sv
